### design/cpuis_pkg.sv
package cpuis_pkg;

  // Interrupt lines that can be pending, and cycles spent entering a handler.
  localparam int unsigned LINE_COUNT       = 5;
  localparam int unsigned IRQ_ENTRY_CYCLES = 5;

  // Lines at or above LINE_COUNT are stored in the flag byte but never pend.
  localparam logic [7:0] LINE_MASK = 8'((9'd1 << LINE_COUNT) - 9'd1);
  localparam logic [3:0] IRQ_ENTRY = 4'(IRQ_ENTRY_CYCLES);
  localparam logic [3:0] VEC_BASE  = 4'b1000;  // 0x40 >> 3

  // Request codes
  localparam logic [2:0] REQ_TICK     = 3'd0;
  localparam logic [2:0] REQ_RAISE    = 3'd1;
  localparam logic [2:0] REQ_WR_ENA   = 3'd2;
  localparam logic [2:0] REQ_WR_FLAG  = 3'd3;
  localparam logic [2:0] REQ_READ     = 3'd4;

  // Action codes
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_ISSUE = 2'd1;
  localparam logic [1:0] ACT_IRQ   = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  // Master-enable effect codes
  localparam logic [1:0] IME_KEEP  = 2'd0;
  localparam logic [1:0] IME_CLEAR = 2'd1;
  localparam logic [1:0] IME_SET   = 2'd2;

  typedef struct packed {
    logic [2:0] req_type;
    logic [2:0] irq_index;
    logic [7:0] write_value;
    logic [3:0] instr_cycles;
    logic [1:0] instr_ime_effect;
    logic       instr_halts;
  } in_item_t;

  typedef struct packed {
    logic [1:0] action;
    logic [6:0] vector_addr;
    logic [2:0] irq_taken;
    logic [7:0] enable_read;
    logic [7:0] flag_read;
    logic       master_enable_out;
    logic       halted_out;
  } out_item_t;

  // Busy counter add, saturating at 15.
  function automatic logic [3:0] sat_add(input logic [3:0] a, input logic [3:0] b);
    logic [4:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[4] ? 4'hF : sum[3:0];
  endfunction

endpackage

### design/cpuis_core.sv
module cpuis_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  cpuis_pkg::in_item_t  item,
  output cpuis_pkg::out_item_t result
);
  import cpuis_pkg::*;

  logic [7:0] enable_r, enable_nxt;
  logic [7:0] flag_r, flag_nxt;
  logic       ime_r, ime_nxt;
  logic       halt_r, halt_nxt;
  logic [3:0] busy_r, busy_nxt;

  logic [7:0] live;
  logic       pending;
  logic [2:0] pick;
  logic       dispatch;
  logic [1:0] action;

  // Lowest pending line
  always_comb begin
    live    = enable_r & flag_r & LINE_MASK;
    pending = |live;
    pick    = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (live[k]) begin
        pick = 3'(k);
      end
    end
  end

  always_comb begin
    enable_nxt = enable_r;
    flag_nxt   = flag_r;
    ime_nxt    = ime_r;
    halt_nxt   = halt_r;
    busy_nxt   = busy_r;
    action     = ACT_NONE;
    dispatch   = halt_r ? pending : (busy_r == 4'd0);

    case (item.req_type)
      REQ_TICK: begin
        if (halt_r && pending) begin
          halt_nxt = 1'b0;
        end
        if (dispatch) begin
          if (ime_r && pending) begin
            action   = ACT_IRQ;
            ime_nxt  = 1'b0;
            flag_nxt = flag_r & ~(8'd1 << pick);
            busy_nxt = sat_add(busy_r, IRQ_ENTRY);
          end else begin
            action   = ACT_ISSUE;
            busy_nxt = sat_add(busy_r, item.instr_cycles);
            case (item.instr_ime_effect)
              IME_CLEAR: ime_nxt = 1'b0;
              IME_SET:   ime_nxt = 1'b1;
              default:   ime_nxt = ime_r;
            endcase
            if (item.instr_halts) begin
              halt_nxt = 1'b1;
            end
          end
        end
        // count down only on a tick that started out running
        if (!halt_r && busy_nxt != 4'd0) begin
          busy_nxt = busy_nxt - 4'd1;
        end
      end
      REQ_RAISE: begin
        if (32'(item.irq_index) < LINE_COUNT) begin
          flag_nxt = flag_r | (8'd1 << item.irq_index);
        end
      end
      REQ_WR_ENA:  enable_nxt = item.write_value;
      REQ_WR_FLAG: flag_nxt   = item.write_value;
      REQ_READ:    action     = ACT_READ;
      default:     action     = ACT_NONE;
    endcase
  end

  // handler address: (0x40 >> 3 + line) << 3
  always_comb begin
    result.action            = action;
    result.vector_addr       = (action == ACT_IRQ) ? {VEC_BASE | {1'b0, pick}, 3'b000} : 7'd0;
    result.irq_taken         = (action == ACT_IRQ) ? pick : 3'd0;
    result.enable_read       = enable_nxt;
    result.flag_read         = flag_nxt;
    result.master_enable_out = ime_nxt;
    result.halted_out        = halt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 8'd0;
      flag_r   <= 8'd0;
      ime_r    <= 1'b0;
      halt_r   <= 1'b0;
      busy_r   <= 4'd0;
    end else if (accept) begin
      enable_r <= enable_nxt;
      flag_r   <= flag_nxt;
      ime_r    <= ime_nxt;
      halt_r   <= halt_nxt;
      busy_r   <= busy_nxt;
    end
  end

endmodule

### design/cpu_interrupt_and_cycle_sequencer.sv
// Channel   Ports                          Moves
// --------  -----------------------------  ------------------------------------
// input     in_valid  in_stall  in_data    one request transaction (in_item_t)
// result    out_valid out_stall out_data   one result transaction (out_item_t)
//
// Each accepted transaction yields exactly one result. The core state and the
// result (into the output register, or the skid when that is held) load at
// the acceptance edge, so the next request sees the new state at once.
// A two-entry output queue (output register plus skid) decouples the sides;
// in_stall is high while the skid holds a result, which only follows a stalled
// result. Reset (rst_n low, synchronous) clears all state and the queue.
module cpu_interrupt_and_cycle_sequencer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  cpuis_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cpuis_pkg::out_item_t out_data
);
  import cpuis_pkg::*;

  out_item_t res;
  out_item_t out_r, out_nxt;
  out_item_t skid_r, skid_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  logic      accept;
  logic      pop;

  // skid full is the only backpressure toward the requester
  assign in_stall  = skid_valid_r;
  assign accept    = in_valid && !skid_valid_r;
  assign pop       = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  cpuis_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_data),
    .result (res)
  );

  // Output queue: the skid entry only fills when the output register is
  // held, and drains into it on the next pop.
  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_r || pop) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

`ifndef SYNTHESIS
  // skid never holds a result while the output register is empty
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid with output register empty");

  // skid only fills when the consumer stalled a pending result
  a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_stall) && $past(out_valid_r))
    else $error("skid filled without output stall");

  // taken interrupt carries the handler address of its line
  a_vector_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.action == ACT_IRQ |->
      out_r.vector_addr == {VEC_BASE | {1'b0, out_r.irq_taken}, 3'b000} &&
      !out_r.master_enable_out)
    else $error("interrupt result with inconsistent vector or master enable");
`endif

endmodule
